// ----- rtl/tcce_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Shared types, command codes, character codes and the character decoder.
// ----------------------------------------------------------------------------
package tcce_pkg;

   localparam int unsigned ColumnWidth   = 8;
   localparam int unsigned RowWidth      = 8;
   localparam int unsigned ColumnCount   = 1 << ColumnWidth;
   localparam int unsigned MaxResults    = 24;
   localparam int unsigned EmitCountWidth = $clog2(MaxResults);
   localparam int unsigned DefaultTabWidth = 4;

   localparam logic [7:0] ResetScreenWidth  = 8'd80;
   localparam logic [7:0] ResetScreenHeight = 8'd25;
   localparam logic [3:0] ResetClearFg      = 4'd0;
   localparam logic [3:0] ResetClearBg      = 4'd15;

   localparam logic [7:0] CharNewline   = 8'h0A;
   localparam logic [7:0] CharReturn    = 8'h0D;
   localparam logic [7:0] CharBackspace = 8'h08;
   localparam logic [7:0] CharTab       = 8'h09;
   localparam logic [7:0] CharFormFeed  = 8'h0C;
   localparam logic [7:0] CharRowUp     = 8'h01;
   localparam logic [7:0] CharSpace     = 8'h20;
   localparam logic [7:0] MaxColumn     = 8'hFF;
   localparam logic [7:0] MaxRow        = 8'hFF;

   typedef enum logic [1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1,
      CSR_CLEAR_FG      = 2'd2,
      CSR_CLEAR_BG      = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_SCROLL = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_CURSOR = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      OP_PRINT,
      OP_NEWLINE,
      OP_RETURN,
      OP_BACKSPACE,
      OP_TAB,
      OP_FORMFEED,
      OP_ROWUP,
      OP_SPACE
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCROLL,
      ST_ACT,
      ST_CURSOR
   } state_type;

   typedef struct packed {
      logic   accept;
      logic   scroll;
      logic   act;
      logic   cursor;
      logic   tab_dec;
      op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_ready;
      logic scroll_hit;
      logic wrap_hit;
      logic tab_last;
   } dp_status_type;

   function automatic op_type decode_char(input logic [7:0] code);
      op_type op;
      unique case (code)
         CharNewline:   op = OP_NEWLINE;
         CharReturn:    op = OP_RETURN;
         CharBackspace: op = OP_BACKSPACE;
         CharTab:       op = OP_TAB;
         CharFormFeed:  op = OP_FORMFEED;
         CharRowUp:     op = OP_ROWUP;
         default:       op = OP_PRINT;
      endcase
      return op;
   endfunction

endpackage

// ----- rtl/tcce_ctrl.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine controller
// Sequences scroll check, character action, wrap newline, tab spaces and the
// final cursor beat for each accepted character.
// ----------------------------------------------------------------------------
module tcce_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_char_code,
   input  tcce_pkg::dp_status_type status,
   output tcce_pkg::ctrl_cmd_type  cmd
);
   import tcce_pkg::*;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      tab_ff, tab_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_PRINT;
         tab_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         tab_ff   <= tab_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      tab_in      = tab_ff;
      cmd         = '0;
      cmd.op      = op_ff;
      req_stall   = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               op_in      = decode_char(req_char_code);
               tab_in     = (decode_char(req_char_code) == OP_TAB);
               state_in   = ST_SCROLL;
            end
         end
         ST_SCROLL: begin
            if (status.out_ready) begin
               cmd.scroll = 1'b1;
               state_in   = ST_ACT;
            end
         end
         ST_ACT: begin
            if (status.out_ready) begin
               cmd.act = 1'b1;
               if (op_ff == OP_TAB) begin
                  op_in    = OP_SPACE;
                  state_in = ST_SCROLL;
               end else if (op_ff != OP_NEWLINE && status.wrap_hit) begin
                  op_in    = OP_NEWLINE;
                  state_in = ST_SCROLL;
               end else if (tab_ff && !status.tab_last) begin
                  cmd.tab_dec = 1'b1;
                  op_in       = OP_SPACE;
                  state_in    = ST_SCROLL;
               end else begin
                  state_in = ST_CURSOR;
               end
            end
         end
         ST_CURSOR: begin
            if (status.out_ready) begin
               cmd.cursor = 1'b1;
               tab_in     = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- rtl/tcce_datapath.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine datapath
// Holds the configuration, the cursor, the tab and beat counters and the
// result register, and forms each result beat.
// ----------------------------------------------------------------------------
module tcce_datapath #(
   parameter int unsigned TAB_WIDTH = tcce_pkg::DefaultTabWidth
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [1:0]              csr_index,
   input  logic [7:0]              csr_write_data,
   input  logic [7:0]              req_char_code,
   input  logic [3:0]              req_fg_colour,
   input  logic [3:0]              req_bg_colour,
   input  tcce_pkg::ctrl_cmd_type  cmd,
   output tcce_pkg::dp_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_command,
   output logic [7:0]              rsp_column,
   output logic [7:0]              rsp_row,
   output logic [7:0]              rsp_glyph,
   output logic [7:0]              rsp_attribute,
   output logic                    rsp_last
);
   import tcce_pkg::*;

   localparam int unsigned TabCountWidth = $clog2(TAB_WIDTH + 1);

   logic [7:0] width_ff, height_ff;
   logic [3:0] clear_fg_ff, clear_bg_ff;
   logic [ColumnWidth-1:0] col_ff, col_in;
   logic [RowWidth-1:0]    row_ff, row_in;
   logic [7:0] char_ff;
   logic [7:0] attr_ff;
   logic [TabCountWidth-1:0]  tab_left_ff, tab_left_in;
   logic [EmitCountWidth-1:0] emit_cnt_ff, emit_cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   command_type rsp_command_ff;
   logic [7:0]  rsp_column_ff, rsp_row_ff, rsp_glyph_ff, rsp_attribute_ff;
   logic        rsp_last_ff;

   logic [TabCountWidth-1:0] tab_fill [ColumnCount];

   logic [7:0] wrap_at;
   logic [ColumnWidth-1:0] col_inc, col_dec, col_act;
   logic [RowWidth-1:0]    row_inc, row_dec, row_act;
   logic        out_ready;
   logic        emit_req, emit_fire;
   command_type e_cmd;
   logic [7:0]  e_col, e_row, e_glyph, e_attr;
   logic        e_last;

   for (genvar i = 0; i < ColumnCount; i++) begin : g_tab
      assign tab_fill[i] = TabCountWidth'(TAB_WIDTH - (i % TAB_WIDTH));
   end

   assign wrap_at   = (width_ff < 8'd2) ? 8'd1 : width_ff - 8'd1;
   assign col_inc   = (col_ff == MaxColumn) ? col_ff : col_ff + 1'b1;
   assign col_dec   = (col_ff == '0) ? col_ff : col_ff - 1'b1;
   assign row_inc   = (row_ff == MaxRow) ? row_ff : row_ff + 1'b1;
   assign row_dec   = (row_ff == '0) ? row_ff : row_ff - 1'b1;
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      col_act = col_ff;
      row_act = row_ff;
      unique case (cmd.op) inside
         OP_NEWLINE: begin
            row_act = row_inc;
            col_act = '0;
         end
         OP_RETURN:    col_act = '0;
         OP_BACKSPACE: col_act = col_dec;
         OP_FORMFEED: begin
            col_act = '0;
            row_act = '0;
         end
         OP_ROWUP:     row_act = row_dec;
         OP_PRINT, OP_SPACE: col_act = col_inc;
         OP_TAB: ;
         default: ;
      endcase
   end

   assign status.out_ready  = out_ready;
   assign status.scroll_hit = (row_ff >= height_ff);
   assign status.wrap_hit   = (col_act >= wrap_at);
   assign status.tab_last   = (tab_left_ff == TabCountWidth'(1));

   always_comb begin
      emit_req = 1'b0;
      e_cmd    = CMD_WRITE;
      e_col    = '0;
      e_row    = '0;
      e_glyph  = '0;
      e_attr   = '0;
      e_last   = 1'b0;
      if (cmd.scroll && status.scroll_hit) begin
         emit_req = 1'b1;
         e_cmd    = CMD_SCROLL;
      end
      if (cmd.act) begin
         case (cmd.op) inside
            OP_BACKSPACE: begin
               emit_req = 1'b1;
               e_col    = col_dec;
               e_row    = row_ff;
               e_glyph  = CharSpace;
               e_attr   = attr_ff;
            end
            OP_FORMFEED: begin
               emit_req = 1'b1;
               e_cmd    = CMD_CLEAR;
               e_attr   = {clear_bg_ff, clear_fg_ff};
            end
            OP_PRINT, OP_SPACE: begin
               emit_req = 1'b1;
               e_col    = col_ff;
               e_row    = row_ff;
               e_glyph  = (cmd.op == OP_SPACE) ? CharSpace : char_ff;
               e_attr   = attr_ff;
            end
            default: ;
         endcase
      end
      if (cmd.cursor) begin
         emit_req = 1'b1;
         e_cmd    = CMD_CURSOR;
         e_col    = col_ff;
         e_row    = row_ff;
         e_last   = 1'b1;
      end
   end

   assign emit_fire = emit_req && out_ready &&
                      (e_last || emit_cnt_ff < EmitCountWidth'(MaxResults - 1));

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      tab_left_in = tab_left_ff;
      emit_cnt_in = emit_cnt_ff;
      if (cmd.scroll && status.scroll_hit) begin
         row_in = row_dec;
      end
      if (cmd.act) begin
         col_in = col_act;
         row_in = row_act;
      end
      if (cmd.accept) begin
         tab_left_in = tab_fill[col_ff];
         emit_cnt_in = '0;
      end else begin
         if (cmd.tab_dec) begin
            tab_left_in = tab_left_ff - 1'b1;
         end
         if (emit_fire && !e_last) begin
            emit_cnt_in = emit_cnt_ff + 1'b1;
         end
      end
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= ResetScreenWidth;
         height_ff    <= ResetScreenHeight;
         clear_fg_ff  <= ResetClearFg;
         clear_bg_ff  <= ResetClearBg;
         col_ff       <= '0;
         row_ff       <= '0;
         tab_left_ff  <= '0;
         emit_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_SCREEN_WIDTH:  width_ff    <= csr_write_data;
               CSR_SCREEN_HEIGHT: height_ff   <= csr_write_data;
               CSR_CLEAR_FG:      clear_fg_ff <= csr_write_data[3:0];
               CSR_CLEAR_BG:      clear_bg_ff <= csr_write_data[3:0];
               default: ;
            endcase
         end
         col_ff       <= col_in;
         row_ff       <= row_in;
         tab_left_ff  <= tab_left_in;
         emit_cnt_ff  <= emit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         char_ff <= req_char_code;
         attr_ff <= {req_bg_colour, req_fg_colour};
      end
      if (emit_fire) begin
         rsp_command_ff   <= e_cmd;
         rsp_column_ff    <= e_col;
         rsp_row_ff       <= e_row;
         rsp_glyph_ff     <= e_glyph;
         rsp_attribute_ff <= e_attr;
         rsp_last_ff      <= e_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_command   = rsp_command_ff;
   assign rsp_column    = rsp_column_ff;
   assign rsp_row       = rsp_row_ff;
   assign rsp_glyph     = rsp_glyph_ff;
   assign rsp_attribute = rsp_attribute_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ----- rtl/text_console_cursor_engine.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine
// Turns each character into a run of screen command beats and keeps the
// cursor column and row.
//
//   Channel  Direction  Handshake          Payload
//   req      in         req_valid/stall    char_code, fg_colour, bg_colour
//   rsp      out        rsp_valid/stall    command, column, row, glyph,
//                                          attribute, last
//   csr      in         csr_write_enable   csr_index, csr_write_data
//
// A plain character goes through accept, scroll check, action and cursor
// beat. Each tab space and a wrap newline repeat scroll check and action.
// The controller handles one character at a time and issues at most one
// result beat per cycle into a single output register.
// A stalled result holds the sequencer in place. Reset is synchronous.
// ----------------------------------------------------------------------------
module text_console_cursor_engine #(
   parameter int unsigned TAB_WIDTH = tcce_pkg::DefaultTabWidth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic [3:0] req_fg_colour,
   input  logic [3:0] req_bg_colour,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_command,
   output logic [7:0] rsp_column,
   output logic [7:0] rsp_row,
   output logic [7:0] rsp_glyph,
   output logic [7:0] rsp_attribute,
   output logic       rsp_last
);
   import tcce_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   tcce_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .status        (status),
      .cmd           (cmd)
   );

   tcce_datapath #(
      .TAB_WIDTH (TAB_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_char_code    (req_char_code),
      .req_fg_colour    (req_fg_colour),
      .req_bg_colour    (req_bg_colour),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command      (rsp_command),
      .rsp_column       (rsp_column),
      .rsp_row          (rsp_row),
      .rsp_glyph        (rsp_glyph),
      .rsp_attribute    (rsp_attribute),
      .rsp_last         (rsp_last)
   );

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine testbench
// Feeds characters into the engine and checks every screen command beat
// against a cycle-free model of the cursor logic kept in the bench. A
// directed table covers the edge cases and is followed by random phases,
// each with its own screen geometry and clear colors.
// ----------------------------------------------------------------------------
module testbench;
   import tcce_pkg::*;

   localparam int TabStop    = DefaultTabWidth;
   localparam int StallLimit = 2000;
   localparam int PhaseCount = 8;
   localparam int PhaseItems = 43;

   typedef struct packed {
      command_type command;
      logic [7:0]  column;
      logic [7:0]  row;
      logic [7:0]  glyph;
      logic [7:0]  attribute;
      logic        last;
   } screen_cmd_type;

   typedef enum {ROW_CHAR, ROW_SETUP} row_kind_type;

   typedef struct {
      row_kind_type   kind;
      logic [7:0]     a;
      logic [7:0]     b;
      logic [3:0]     fg;
      logic [3:0]     bg;
      int             n_typed;
      screen_cmd_type typed [2];
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_write_data = '0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_code = '0;
   logic [3:0] req_fg_colour = '0;
   logic [3:0] req_bg_colour = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_command;
   logic [7:0] rsp_column;
   logic [7:0] rsp_row;
   logic [7:0] rsp_glyph;
   logic [7:0] rsp_attribute;
   logic       rsp_last;

   logic [7:0] cur_column = '0;
   logic [7:0] cur_row = '0;
   logic [7:0] width_reg = ResetScreenWidth;
   logic [7:0] height_reg = ResetScreenHeight;
   logic [3:0] clr_fg = ResetClearFg;
   logic [3:0] clr_bg = ResetClearBg;

   screen_cmd_type char_cmds [$];
   screen_cmd_type screen_cmds_due [$];
   stim_row_type   stim_table [$];

   int  mismatches = 0;
   int  quiet_cycles = 0;
   int  stall_burst = 0;
   bit  idle_enable = 1'b0;

   text_console_cursor_engine #(
      .TAB_WIDTH(TabStop)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_fg_colour    (req_fg_colour),
      .req_bg_colour    (req_bg_colour),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command      (rsp_command),
      .rsp_column       (rsp_column),
      .rsp_row          (rsp_row),
      .rsp_glyph        (rsp_glyph),
      .rsp_attribute    (rsp_attribute),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic screen_cmd_type beat(command_type cmd, logic [7:0] col, logic [7:0] row,
                                           logic [7:0] glyph, logic [7:0] attr, logic last);
      screen_cmd_type b;
      b = '{command: cmd, column: col, row: row, glyph: glyph, attribute: attr, last: last};
      return b;
   endfunction

   task automatic post_cmd(command_type cmd, logic [7:0] col, logic [7:0] row,
                           logic [7:0] glyph, logic [7:0] attr, logic last);
      if (char_cmds.size() >= MaxResults - 1 && !last) return;
      if (char_cmds.size() >= MaxResults) return;
      char_cmds.push_back(beat(cmd, col, row, glyph, attr, last));
   endtask

   task automatic scroll_check();
      if (cur_row >= height_reg) begin
         post_cmd(CMD_SCROLL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
         if (cur_row > 0) cur_row = cur_row - 8'd1;
      end
   endtask

   task automatic wrap_check();
      int wrap_at;
      wrap_at = (width_reg < 2) ? 1 : int'(width_reg) - 1;
      if (int'(cur_column) >= wrap_at) begin
         scroll_check();
         if (cur_row < MaxRow) cur_row = cur_row + 8'd1;
         cur_column = '0;
      end
   endtask

   task automatic put_glyph(logic [7:0] code, logic [7:0] attr);
      post_cmd(CMD_WRITE, cur_column, cur_row, code, attr, 1'b0);
      if (cur_column < MaxColumn) cur_column = cur_column + 8'd1;
   endtask

   task automatic render_char(logic [7:0] code, logic [3:0] fg, logic [3:0] bg);
      logic [7:0] attr;
      int         spaces;
      attr = {bg, fg};
      char_cmds.delete();
      scroll_check();
      case (code)
         CharNewline: begin
            if (cur_row < MaxRow) cur_row = cur_row + 8'd1;
            cur_column = '0;
         end
         CharReturn: begin
            cur_column = '0;
         end
         CharBackspace: begin
            if (cur_column > 0) cur_column = cur_column - 8'd1;
            post_cmd(CMD_WRITE, cur_column, cur_row, CharSpace, attr, 1'b0);
         end
         CharTab: begin
            spaces = TabStop - (int'(cur_column) % TabStop);
            repeat (spaces) begin
               scroll_check();
               put_glyph(CharSpace, attr);
               wrap_check();
            end
         end
         CharFormFeed: begin
            cur_column = '0;
            cur_row = '0;
            post_cmd(CMD_CLEAR, 8'd0, 8'd0, 8'd0, {clr_bg, clr_fg}, 1'b0);
         end
         CharRowUp: begin
            if (cur_row > 0) cur_row = cur_row - 8'd1;
         end
         default: begin
            put_glyph(code, attr);
         end
      endcase
      wrap_check();
      post_cmd(CMD_CURSOR, cur_column, cur_row, 8'd0, 8'd0, 1'b1);
   endtask

   task automatic add_row(row_kind_type kind, logic [7:0] a, logic [7:0] b, logic [3:0] fg,
                          logic [3:0] bg, int n_typed = 0, screen_cmd_type t0 = '0,
                          screen_cmd_type t1 = '0);
      stim_row_type r;
      r.kind = kind;
      r.a = a;
      r.b = b;
      r.fg = fg;
      r.bg = bg;
      r.n_typed = n_typed;
      r.typed[0] = t0;
      r.typed[1] = t1;
      stim_table.push_back(r);
   endtask

   task automatic send_char(logic [7:0] code, logic [3:0] fg, logic [3:0] bg,
                            int n_typed = 0, screen_cmd_type t0 = '0,
                            screen_cmd_type t1 = '0);
      req_char_code <= code;
      req_fg_colour <= fg;
      req_bg_colour <= bg;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!(req_valid && !req_stall)) @(posedge clock);
      render_char(code, fg, bg);
      if (n_typed == 0) begin
         foreach (char_cmds[k]) screen_cmds_due.push_back(char_cmds[k]);
      end else begin
         screen_cmds_due.push_back(t0);
         if (n_typed > 1) screen_cmds_due.push_back(t1);
      end
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (screen_cmds_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_config(logic [7:0] w, logic [7:0] h, logic [3:0] fg, logic [3:0] bg);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_SCREEN_WIDTH;
      csr_write_data <= w;
      @(posedge clock);
      width_reg = w;
      csr_index <= CSR_SCREEN_HEIGHT;
      csr_write_data <= h;
      @(posedge clock);
      height_reg = h;
      csr_index <= CSR_CLEAR_FG;
      csr_write_data <= {4'h0, fg};
      @(posedge clock);
      clr_fg = fg;
      csr_index <= CSR_CLEAR_BG;
      csr_write_data <= {4'h0, bg};
      @(posedge clock);
      clr_bg = bg;
      csr_write_enable <= 1'b0;
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      screen_cmd_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (screen_cmds_due.size() == 0) begin
            $error("unexpected beat: command 0x%0h column 0x%0h row 0x%0h",
                   rsp_command, rsp_column, rsp_row);
            mismatches++;
         end else begin
            want = screen_cmds_due.pop_front();
            check_field("command", want.command, rsp_command);
            check_field("column", want.column, rsp_column);
            check_field("row", want.row, rsp_row);
            check_field("glyph", want.glyph, rsp_glyph);
            check_field("attribute", want.attribute, rsp_attribute);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || !idle_enable) begin
         rsp_stall <= 1'b0;
         stall_burst <= 0;
      end else if (stall_burst > 0) begin
         rsp_stall <= 1'b1;
         stall_burst <= stall_burst - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         stall_burst <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("testbench: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] pick_width();
      case ($urandom_range(0, 7))
         0: return 8'($urandom_range(0, 1));
         1: return 8'd255;
         2: return 8'd80;
         default: return 8'($urandom_range(2, 12));
      endcase
   endfunction

   function automatic logic [7:0] pick_height();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd25;
         default: return 8'($urandom_range(1, 6));
      endcase
   endfunction

   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 9))
         0: return CharNewline;
         1: return CharTab;
         2: begin
            case ($urandom_range(0, 6)) inside
               0: return CharFormFeed;
               1, 2: return CharReturn;
               3, 4: return CharBackspace;
               default: return CharRowUp;
            endcase
         end
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      add_row(ROW_CHAR, 8'h41, 8'h00, 4'hF, 4'h0, 2,
              beat(CMD_WRITE, 8'd0, 8'd0, 8'h41, 8'h0F, 1'b0),
              beat(CMD_CURSOR, 8'd1, 8'd0, 8'd0, 8'd0, 1'b1));
      add_row(ROW_CHAR, 8'h00, 8'h00, 4'h0, 4'h0, 2,
              beat(CMD_WRITE, 8'd1, 8'd0, 8'h00, 8'h00, 1'b0),
              beat(CMD_CURSOR, 8'd2, 8'd0, 8'd0, 8'd0, 1'b1));
      add_row(ROW_CHAR, 8'hFF, 8'h00, 4'hF, 4'hF, 2,
              beat(CMD_WRITE, 8'd2, 8'd0, 8'hFF, 8'hFF, 1'b0),
              beat(CMD_CURSOR, 8'd3, 8'd0, 8'd0, 8'd0, 1'b1));
      add_row(ROW_CHAR, 8'h7F, 8'h00, 4'h5, 4'hA);
      add_row(ROW_CHAR, CharBackspace, 8'h00, 4'h1, 4'h2, 2,
              beat(CMD_WRITE, 8'd3, 8'd0, CharSpace, 8'h21, 1'b0),
              beat(CMD_CURSOR, 8'd3, 8'd0, 8'd0, 8'd0, 1'b1));
      add_row(ROW_CHAR, CharReturn, 8'h00, 4'h0, 4'h0, 1,
              beat(CMD_CURSOR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
      add_row(ROW_CHAR, CharBackspace, 8'h00, 4'h3, 4'h4, 2,
              beat(CMD_WRITE, 8'd0, 8'd0, CharSpace, 8'h43, 1'b0),
              beat(CMD_CURSOR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
      add_row(ROW_CHAR, CharRowUp, 8'h00, 4'h0, 4'h0, 1,
              beat(CMD_CURSOR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
      add_row(ROW_CHAR, CharNewline, 8'h00, 4'h0, 4'h0, 1,
              beat(CMD_CURSOR, 8'd0, 8'd1, 8'd0, 8'd0, 1'b1));
      add_row(ROW_CHAR, CharTab, 8'h00, 4'h6, 4'h9);
      add_row(ROW_CHAR, 8'h78, 8'h00, 4'h7, 4'h8);
      add_row(ROW_CHAR, CharTab, 8'h00, 4'hA, 4'h5);
      add_row(ROW_CHAR, CharRowUp, 8'h00, 4'h0, 4'h0);
      add_row(ROW_CHAR, CharFormFeed, 8'h00, 4'h2, 4'h3, 2,
              beat(CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'hF0, 1'b0),
              beat(CMD_CURSOR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
      add_row(ROW_CHAR, 8'h0B, 8'h00, 4'hC, 4'h3);
      add_row(ROW_CHAR, CharSpace, 8'h00, 4'h1, 4'hE);
      add_row(ROW_SETUP, 8'd1, 8'd0, 4'hF, 4'h0);
      add_row(ROW_CHAR, 8'h61, 8'h00, 4'h4, 4'hB);
      add_row(ROW_CHAR, CharTab, 8'h00, 4'h9, 4'h6);
      add_row(ROW_CHAR, CharNewline, 8'h00, 4'h0, 4'h0);
      add_row(ROW_CHAR, CharRowUp, 8'h00, 4'h0, 4'h0);
      add_row(ROW_CHAR, CharFormFeed, 8'h00, 4'h0, 4'h0);
      add_row(ROW_CHAR, CharBackspace, 8'h00, 4'h8, 4'h7);
      add_row(ROW_CHAR, CharReturn, 8'h00, 4'h0, 4'h0);
      add_row(ROW_SETUP, 8'd255, 8'd255, 4'h9, 4'h6);
      add_row(ROW_CHAR, CharTab, 8'h00, 4'h3, 4'hC);
      add_row(ROW_CHAR, 8'h5A, 8'h00, 4'hE, 4'h1);
      add_row(ROW_CHAR, CharNewline, 8'h00, 4'h0, 4'h0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      idle_enable = 1'b1;

      foreach (stim_table[i]) begin
         if (stim_table[i].kind == ROW_SETUP) begin
            drain();
            write_config(stim_table[i].a, stim_table[i].b, stim_table[i].fg, stim_table[i].bg);
         end else begin
            send_char(stim_table[i].a, stim_table[i].fg, stim_table[i].bg,
                      stim_table[i].n_typed, stim_table[i].typed[0], stim_table[i].typed[1]);
         end
      end

      for (int phase = 0; phase < PhaseCount; phase++) begin
         drain();
         write_config(pick_width(), pick_height(), 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)));
         idle_enable = (phase != PhaseCount - 1) && ($urandom_range(0, 3) != 0);
         for (int i = 0; i < PhaseItems; i++) begin
            if (phase == PhaseCount / 2 && i == PhaseItems / 2) drain();
            send_char(pick_char(), 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
